### design/dgls_pkg.sv
// ----------------------------------------------------------------------------
// dgls_pkg
// Shared types and constants of the diagonal Gaussian log likelihood scorer.
// ----------------------------------------------------------------------------
package dgls_pkg;

  localparam int NUM_COMPONENTS_DEF = 16;
  localparam int NUM_DIMS_DEF       = 64;
  localparam int FRAC_BITS_DEF      = 16;

  // at most this many results per row
  localparam int RESULT_LIMIT = 16;

  // register stages of the per-component term datapath
  localparam int TERM_LAT = 9;

  // ln(2*pi) in Q32.32
  localparam logic [63:0] LN_TWO_PI_Q32 = 64'd7893621894;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_OBS  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         component;
    logic [5:0]         dim;
    logic signed [31:0] value;
    logic [31:0]        precision;
    logic signed [31:0] log_variance;
    logic               observed;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         comp_index;
    logic signed [47:0] log_likelihood;
    logic               saturated;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] mean;
    logic [31:0]        precision;
    logic signed [31:0] log_variance;
  } param_t;

endpackage

### design/dgls_term.sv
// ----------------------------------------------------------------------------
// dgls_term
// Pipelined per-component term: -0.5*(ln 2pi + log_variance + prec*diff^2).
// ----------------------------------------------------------------------------
module dgls_term #(
  parameter int FRAC_BITS = dgls_pkg::FRAC_BITS_DEF,
  parameter int TAG_W     = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic [TAG_W-1:0]   in_tag,
  input  logic signed [31:0] x,
  input  dgls_pkg::param_t   p,
  output logic               out_vld,
  output logic [TAG_W-1:0]   out_tag,
  output logic signed [63:0] contrib
);
  import dgls_pkg::*;

  localparam int SQW = 64 - FRAC_BITS;
  localparam int SHW = SQW - 32;
  localparam int PW  = SQW + 32;
  localparam logic signed [63:0] LN_TWO_PI =
    64'((LN_TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
  localparam logic [61:0] QUAD_CAP = 62'd1 << 61;

  logic signed [32:0] diff;
  logic [31:0]        mag;
  logic               ovf;

  logic [31:0]        mag1, prec1, prec2, prec3, prec4;
  logic signed [31:0] lv1, lv2, lv3, lv4, lv5, lv6;
  logic [63:0]        m2;
  logic [SQW-1:0]     sq3;
  logic [63:0]        plo4, plo5;
  logic [SHW-1:0]     sqhi4;
  logic [SHW+31:0]    phi5;
  logic [PW-1:0]      p6;
  logic [61:0]        quad7;
  logic signed [63:0] s7, sum8;

  logic [TERM_LAT-1:0] vsr;
  logic [TAG_W-1:0]    tsr [TERM_LAT];

  assign diff = {x[31], x} - {p.mean[31], p.mean};
  assign mag  = diff[32] ? 32'(-diff) : diff[31:0];
  assign ovf  = |p6[PW-1:64];

  always_ff @(posedge clk) begin
    mag1  <= mag;
    prec1 <= p.precision;
    lv1   <= p.log_variance;

    m2    <= 64'(mag1) * 64'(mag1);
    prec2 <= prec1;
    lv2   <= lv1;

    sq3   <= m2[63:FRAC_BITS] + SQW'(m2[FRAC_BITS-1]);
    prec3 <= prec2;
    lv3   <= lv2;

    plo4  <= 64'(sq3[31:0]) * 64'(prec3);
    sqhi4 <= sq3[SQW-1:32];
    prec4 <= prec3;
    lv4   <= lv3;

    phi5  <= (SHW+32)'(sqhi4) * (SHW+32)'(prec4);
    plo5  <= plo4;
    lv5   <= lv4;

    p6    <= {phi5, 32'd0} + PW'(plo5);
    lv6   <= lv5;

    quad7 <= ovf ? QUAD_CAP : 62'(p6[63:FRAC_BITS]);
    s7    <= LN_TWO_PI + {{32{lv6[31]}}, lv6};

    sum8  <= s7 + $signed({2'b00, quad7});

    // halve toward zero, then negate
    contrib <= sum8[63] ? ((-sum8) >>> 1) : -(sum8 >>> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vsr <= '0;
    end else begin
      vsr <= {vsr[TERM_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    tsr[0] <= in_tag;
    for (int i = 1; i < TERM_LAT; i++) begin
      tsr[i] <= tsr[i-1];
    end
  end

  assign out_vld = vsr[TERM_LAT-1];
  assign out_tag = tsr[TERM_LAT-1];

endmodule

### design/diag_gaussian_loglik_scorer.sv
// ----------------------------------------------------------------------------
// diag_gaussian_loglik_scorer
// Diagonal-covariance Gaussian mixture scorer with per-component accumulators.
//
//   channel   signals                           payload
//   item      item_valid / item_stall / item    in_item_t
//   result    result_valid / result_stall /     out_item_t
//             result
//
// An observed element sweeps one parameter memory read per component over
// min(NUM_COMPONENTS,16) components, then drains the 9-stage term pipeline and
// the accumulate stage. Missing elements are taken without a sweep. The last
// element emits results from the accumulator memory, each once the result
// register is free. One item waits in the input register during that work.
// Reset clears control and accumulator valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module diag_gaussian_loglik_scorer #(
  parameter int NUM_COMPONENTS = dgls_pkg::NUM_COMPONENTS_DEF,
  parameter int NUM_DIMS       = dgls_pkg::NUM_DIMS_DEF,
  parameter int FRAC_BITS      = dgls_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  dgls_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output dgls_pkg::out_item_t result
);
  import dgls_pkg::*;

  localparam int EMIT  = (NUM_COMPONENTS < RESULT_LIMIT) ? NUM_COMPONENTS : RESULT_LIMIT;
  localparam int DEPTH = NUM_COMPONENTS * NUM_DIMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(EMIT);
  localparam int DW    = $clog2(TERM_LAT + 2);
  localparam logic signed [63:0] ACC_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] ACC_MIN = -64'sd140737488355328;

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DRAIN, ST_EMIT} state_t;

  typedef struct packed {
    logic               clip;
    logic signed [47:0] acc;
  } acc_t;

  state_t         state;
  in_item_t       cur;
  logic           cur_vld;
  logic           take;
  logic           hit;
  logic           ld_we;
  logic [AW-1:0]  wa;
  logic [AW-1:0]  addr;
  logic [KW-1:0]  cnt;
  logic [KW-1:0]  ecnt;
  logic [DW-1:0]  dcnt;
  logic           er_pend;
  logic           out_free;
  logic           emit_done;

  param_t         pmem [DEPTH];
  param_t         pm_q;
  logic           rd_vld;
  logic [KW-1:0]  rd_k;

  logic               t_vld;
  logic [KW-1:0]      t_k;
  logic signed [63:0] t_c;

  acc_t               acc_mem [EMIT];
  logic [EMIT-1:0]    acc_vld;
  logic [KW-1:0]      raddr;
  acc_t               acc_q;
  logic               acc_qv;
  acc_t               acc_old;
  acc_t               acc_new;
  logic               a_vld;
  logic [KW-1:0]      a_k;
  logic signed [63:0] a_c;
  logic signed [63:0] acc_sum;

  // input register
  assign hit = cur.observed && (32'(cur.dim) < NUM_DIMS);

  always_comb begin
    take = 1'b0;
    case (state)
      ST_IDLE:  take = cur_vld && !(cur.cmd == CMD_OBS && hit);
      ST_DRAIN: take = (dcnt == '0);
      default:  take = 1'b0;
    endcase
  end

  assign item_stall = cur_vld && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vld <= 1'b0;
    end else if (item_valid && !item_stall) begin
      cur_vld <= 1'b1;
    end else if (take) begin
      cur_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      cur <= item;
    end
  end

  // parameter memory
  assign ld_we = (state == ST_IDLE) && cur_vld && (cur.cmd == CMD_LOAD) &&
                 (32'(cur.component) < NUM_COMPONENTS) && (32'(cur.dim) < NUM_DIMS);
  assign wa    = AW'(32'(cur.component) * 32'(NUM_DIMS) + 32'(cur.dim));

  always_ff @(posedge clk) begin
    if (ld_we) begin
      pmem[wa] <= '{mean: cur.value, precision: cur.precision,
                    log_variance: cur.log_variance};
    end
    pm_q <= pmem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SWEEP);
    end
    rd_k <= cnt;
  end

  dgls_term #(
    .FRAC_BITS (FRAC_BITS),
    .TAG_W     (KW)
  ) u_term (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (rd_vld),
    .in_tag  (rd_k),
    .x       (cur.value),
    .p       (pm_q),
    .out_vld (t_vld),
    .out_tag (t_k),
    .contrib (t_c)
  );

  // accumulator memory, read-modify-write
  assign raddr = (state == ST_EMIT) ? ecnt : t_k;

  always_ff @(posedge clk) begin
    acc_q  <= acc_mem[raddr];
    acc_qv <= acc_vld[raddr];
    a_k    <= t_k;
    a_c    <= t_c;
    if (a_vld) begin
      acc_mem[a_k] <= acc_new;
    end
  end

  assign acc_old = acc_qv ? acc_q : '0;
  assign acc_sum = $signed({{16{acc_old.acc[47]}}, acc_old.acc}) + a_c;

  always_comb begin
    acc_new.clip = acc_old.clip;
    acc_new.acc  = acc_sum[47:0];
    if (acc_sum > ACC_MAX) begin
      acc_new.acc  = ACC_MAX[47:0];
      acc_new.clip = 1'b1;
    end else if (acc_sum < ACC_MIN) begin
      acc_new.acc  = ACC_MIN[47:0];
      acc_new.clip = 1'b1;
    end
  end

  assign emit_done = (state == ST_EMIT) && er_pend && (ecnt == KW'(EMIT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld   <= 1'b0;
      acc_vld <= '0;
    end else begin
      a_vld <= t_vld;
      if (emit_done) begin
        acc_vld <= '0;
      end else if (a_vld) begin
        acc_vld[a_k] <= 1'b1;
      end
    end
  end

  // sequencer and result register
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      ecnt         <= '0;
      dcnt         <= '0;
      er_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cur_vld && cur.cmd == CMD_OBS) begin
            if (hit) begin
              state <= ST_SWEEP;
              cnt   <= '0;
              addr  <= AW'(cur.dim);
            end else if (cur.last) begin
              state <= ST_EMIT;
              ecnt  <= '0;
            end
          end
        end
        ST_SWEEP: begin
          cnt  <= cnt + KW'(1);
          addr <= addr + AW'(NUM_DIMS);
          if (cnt == KW'(EMIT - 1)) begin
            state <= ST_DRAIN;
            dcnt  <= DW'(TERM_LAT + 1);
          end
        end
        ST_DRAIN: begin
          if (dcnt == '0) begin
            state <= cur.last ? ST_EMIT : ST_IDLE;
            ecnt  <= '0;
          end else begin
            dcnt <= dcnt - DW'(1);
          end
        end
        ST_EMIT: begin
          if (er_pend) begin
            result_valid          <= 1'b1;
            result.comp_index     <= 4'(ecnt);
            result.log_likelihood <= acc_old.acc;
            result.saturated      <= acc_old.clip;
            result.last_of_run    <= (ecnt == KW'(EMIT - 1));
            er_pend               <= 1'b0;
            ecnt                  <= ecnt + KW'(1);
            if (ecnt == KW'(EMIT - 1)) begin
              state <= ST_IDLE;
            end
          end else if (out_free) begin
            er_pend <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### dv/diag_gaussian_loglik_scorer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diag_gaussian_loglik_scorer_tb
// Self-checking bench for the diagonal Gaussian mixture scorer. Parameter
// loads and observation rows go in through the item channel. A scoreboard
// keeps its own copy of the parameter tables and the per-component
// accumulators. It predicts the scores of every row and checks each score
// transfer in order. Sender gaps and receiver stalls vary by phase, and one
// long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module diag_gaussian_loglik_scorer_tb;
  import dgls_pkg::*;

  localparam int     NCOMP        = NUM_COMPONENTS_DEF;
  localparam int     NDIM         = NUM_DIMS_DEF;
  localparam int     NUM_SCORES   = (NCOMP < RESULT_LIMIT) ? NCOMP : RESULT_LIMIT;
  localparam int     FX_SHIFT     = 32 - FRAC_BITS_DEF;
  localparam longint LN_TWO_PI_FX =
    longint'((LN_TWO_PI_Q32 + (64'd1 << (FX_SHIFT - 1))) >> FX_SHIFT);
  localparam longint QUAD_CAP     = 64'sh2000_0000_0000_0000;
  localparam longint ACC_MAX      = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_MIN      = -ACC_MAX - 1;
  localparam int     SETTLE       = 2 * RESULT_LIMIT + NCOMP + TERM_LAT + 24;
  localparam int     CYCLE_LIMIT  = 500_000;

  class loglik_scoreboard;
    logic signed [31:0] mean_mem   [0:NCOMP*NDIM-1];
    logic        [31:0] prec_mem   [0:NCOMP*NDIM-1];
    logic signed [31:0] logvar_mem [0:NCOMP*NDIM-1];
    longint             acc        [0:NCOMP-1];
    bit                 clipped    [0:NCOMP-1];
    out_item_t          scores_due [$];
    int                 errors;

    function new();
      errors = 0;
      foreach (acc[k]) begin
        acc[k]     = 0;
        clipped[k] = 1'b0;
      end
    endfunction

    // log density term of one component and one dimension
    function longint term_of(logic signed [31:0] x, logic signed [31:0] mu,
                             logic [31:0] prec, logic signed [31:0] lv);
      logic [32:0] diff, mag;
      logic [63:0] sq_full;
      logic [48:0] sq;
      logic [80:0] prod;
      longint      quad, total;
      diff    = {x[31], x} - {mu[31], mu};
      mag     = diff[32] ? -diff : diff;
      sq_full = 64'(mag[31:0]) * 64'(mag[31:0]);
      sq      = 49'(sq_full[63:16]) + 49'(sq_full[15]);
      prod    = 81'(sq) * 81'(prec);
      if (|prod[80:64]) begin
        quad = QUAD_CAP;
      end else begin
        quad = longint'(prod[63:16]);
        if (quad > QUAD_CAP) quad = QUAD_CAP;
      end
      total = LN_TWO_PI_FX + longint'(lv) + quad;
      return -(total / 2);
    endfunction

    function void note_item(in_item_t it);
      int     idx;
      longint sum;
      out_item_t want;
      if (it.cmd == CMD_LOAD) begin
        idx = int'(it.component) * NDIM + int'(it.dim);
        mean_mem[idx]   = it.value;
        prec_mem[idx]   = it.precision;
        logvar_mem[idx] = it.log_variance;
        return;
      end
      if (it.observed) begin
        for (int k = 0; k < NCOMP; k++) begin
          idx = k * NDIM + int'(it.dim);
          sum = acc[k] + term_of(it.value, mean_mem[idx], prec_mem[idx], logvar_mem[idx]);
          if (sum > ACC_MAX) begin
            sum        = ACC_MAX;
            clipped[k] = 1'b1;
          end
          if (sum < ACC_MIN) begin
            sum        = ACC_MIN;
            clipped[k] = 1'b1;
          end
          acc[k] = sum;
        end
      end
      if (it.last) begin
        for (int k = 0; k < NUM_SCORES; k++) begin
          want.comp_index     = 4'(k);
          want.log_likelihood = acc[k][47:0];
          want.saturated      = clipped[k];
          want.last_of_run    = (k == NUM_SCORES - 1);
          scores_due.push_back(want);
        end
        foreach (acc[k]) begin
          acc[k]     = 0;
          clipped[k] = 1'b0;
        end
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (scores_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected score transfer: comp %0d log_likelihood %0d",
                 $time, got.comp_index, got.log_likelihood);
        return;
      end
      want = scores_due.pop_front();
      if (got.comp_index !== want.comp_index) begin
        errors++;
        $display("%0t: comp_index expected %0d actual %0d",
                 $time, want.comp_index, got.comp_index);
      end
      if (got.log_likelihood !== want.log_likelihood) begin
        errors++;
        $display("%0t: comp %0d log_likelihood expected %0d actual %0d",
                 $time, want.comp_index, want.log_likelihood, got.log_likelihood);
      end
      if (got.saturated !== want.saturated) begin
        errors++;
        $display("%0t: comp %0d saturated expected %0b actual %0b",
                 $time, want.comp_index, want.saturated, got.saturated);
      end
      if (got.last_of_run !== want.last_of_run) begin
        errors++;
        $display("%0t: comp %0d last_of_run expected %0b actual %0b",
                 $time, want.comp_index, want.last_of_run, got.last_of_run);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result;

  loglik_scoreboard sb;
  bit loaded [0:NCOMP-1][0:NDIM-1];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  bit hold_token = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int sent_count = 0;
  int cycle_count = 0;

  diag_gaussian_loglik_scorer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d scores outstanding", $time, sb.scores_due.size());
      $display("diag_gaussian_loglik_scorer regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen    <= hold_token;
      hold_left    <= hold_len;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return $urandom;
      default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_precision();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return 32'($urandom_range(0, 32'h0004_0000));
    endcase
  endfunction

  function automatic logic [31:0] rand_log_var();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom;
      default: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    endcase
  endfunction

  // a dimension may be observed only once every component has its entry
  function automatic int pick_ready_dim();
    int ready[$];
    bit full;
    for (int d = 0; d < NDIM; d++) begin
      full = 1'b1;
      for (int c = 0; c < NCOMP; c++) begin
        if (!loaded[c][d]) full = 1'b0;
      end
      if (full) ready.push_back(d);
    end
    if (ready.size() == 0) return -1;
    return ready[$urandom_range(0, ready.size() - 1)];
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    sent_count++;
    sb.note_item(it);
    if (it.cmd == CMD_LOAD) loaded[it.component][it.dim] = 1'b1;
  endtask

  task automatic load_entry(input logic [3:0] c, input logic [5:0] d,
                            input logic [31:0] mu, input logic [31:0] prec,
                            input logic [31:0] lv, input logic last_bit);
    in_item_t it;
    it.cmd          = CMD_LOAD;
    it.component    = c;
    it.dim          = d;
    it.value        = mu;
    it.precision    = prec;
    it.log_variance = lv;
    it.observed     = 1'($urandom);
    it.last         = last_bit;
    send_item(it);
  endtask

  task automatic obs_item(input logic [5:0] d, input logic [31:0] x,
                          input logic obs, input logic last_bit);
    in_item_t it;
    it.cmd          = CMD_OBS;
    it.component    = 4'($urandom);
    it.dim          = d;
    it.value        = x;
    it.precision    = $urandom;
    it.log_variance = $urandom;
    it.observed     = obs;
    it.last         = last_bit;
    send_item(it);
  endtask

  task automatic sweep_dim(input logic [5:0] d);
    for (int c = 0; c < NCOMP; c++) begin
      load_entry(4'(c), d, rand_sample(), rand_precision(), rand_log_var(), 1'($urandom));
    end
  endtask

  task automatic score_row(input int len);
    int d;
    for (int i = 0; i < len; i++) begin
      d = pick_ready_dim();
      if (d >= 0 && $urandom_range(0, 4) != 0) begin
        obs_item(6'(d), rand_sample(), 1'b1, i == len - 1);
      end else begin
        obs_item(6'($urandom), rand_sample(), 1'b0, i == len - 1);
      end
    end
  endtask

  task automatic drain_scores();
    item_valid <= 1'b0;
    while (sb.scores_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(input int n, input int idle_pct, input int stall_pct,
                              input int hold);
    int start, r;
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    if (hold > 0) begin
      hold_len   <= hold;
      hold_token <= ~hold_token;
    end
    start = sent_count;
    while (sent_count - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 8 || pick_ready_dim() < 0) begin
        sweep_dim(6'($urandom));
      end else if (r < 22) begin
        load_entry(4'($urandom), 6'($urandom), rand_sample(), rand_precision(),
                   rand_log_var(), 1'($urandom));
      end else begin
        score_row($urandom_range(1, 8));
      end
    end
    drain_scores();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme parameters at dimension 0
    load_entry(4'd0, 6'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
    load_entry(4'd1, 6'd0, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
    load_entry(4'd2, 6'd0, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b0);
    for (int c = 3; c < NCOMP; c++) begin
      load_entry(4'(c), 6'd0, rand_sample(), rand_precision(), rand_log_var(), 1'(c));
    end
    obs_item(6'd0, 32'h0000_0000, 1'b1, 1'b1);
    obs_item(6'd5, rand_sample(), 1'b0, 1'b1);              // all-missing row
    obs_item(6'd0, 32'h8000_0000, 1'b1, 1'b0);
    obs_item(6'd0, 32'h7FFF_FFFF, 1'b1, 1'b0);
    obs_item(6'd63, rand_sample(), 1'b0, 1'b1);             // missing on last
    load_entry(4'd15, 6'd0, 32'h0002_0000, 32'h0000_8000, 32'hFFFF_0000, 1'b1);
    obs_item(6'd0, 32'h0001_8000, 1'b1, 1'b1);
    drain_scores();

    random_phase(115, 0, 0, 400);
    random_phase(115, 70, 0, 0);
    random_phase(115, 0, 70, 0);
    random_phase(115, 8, 8, 0);

    if (sb.errors == 0 && sb.scores_due.size() == 0) begin
      $display("diag_gaussian_loglik_scorer regression: pass");
    end else begin
      $display("diag_gaussian_loglik_scorer regression: fail");
    end
    $finish;
  end

endmodule

### files.f
design/dgls_pkg.sv
design/dgls_term.sv
design/diag_gaussian_loglik_scorer.sv
dv/diag_gaussian_loglik_scorer_tb.sv
